// ===== sv/fmb_pkg.sv =====
// ----------------------------------------------------------------------------
// fmb_pkg
// Shared types, widths and helpers for the mirror-padded FIR core.
// ----------------------------------------------------------------------------
package fmb_pkg;

    localparam int MAX_TAPS   = 7;
    localparam int HIST_DEPTH = 2 * (MAX_TAPS / 2) + 1;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 20;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_BITS  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_TDATA_W = 24;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT = 3'd0,
        REG_COEF_0    = 3'd1,
        REG_COEF_1    = 3'd2,
        REG_COEF_2    = 3'd3,
        REG_COEF_3    = 3'd4,
        REG_COEF_4    = 3'd5,
        REG_COEF_5    = 3'd6,
        REG_COEF_6    = 3'd7
    } reg_index_t;

    // History slot (0 = newest) read by tap j for the output d samples
    // before the newest, with c samples held and centre offset off.
    function automatic logic [2:0] mirror_index(input logic [2:0] c,
                                                input logic [1:0] d,
                                                input logic [1:0] off,
                                                input logic [2:0] j);
        logic signed [5:0] top;
        logic signed [5:0] x;
        logic signed [5:0] p;
        logic signed [5:0] r;
        logic signed [5:0] k;
        top = $signed({3'b000, c}) - 6'sd1;
        x   = top - $signed({4'b0000, d}) + $signed({3'b000, j})
              - $signed({4'b0000, off});
        p   = (x < 6'sd0) ? -x : x;
        r   = p - top;
        if (r > 6'sd0)
            p = top - r;
        if (p < 6'sd0)
            p = 6'sd0;
        if (p > top)
            p = top;
        k = top - p;
        return k[2:0];
    endfunction

endpackage

// ===== sv/fir_filter_mirror_boundary_core.sv =====
// ----------------------------------------------------------------------------
// fir_filter_mirror_boundary_core
// Streaming FIR of up to seven taps with mirror padding at both profile ends.
// ----------------------------------------------------------------------------
// Path: a result reaches m_axis_tvalid through the issue register (loaded at
// the sample transaction), then the product and output registers.
// Throughput: one sample per cycle while m_axis_tready holds; the
// end-of-profile sample holds the input until the single issue slot has sent
// each of its pending outputs (up to three after the first).
// Reset (rst_n low, asynchronous): history and count cleared, tap_count = 1,
// coef_0 = 1.0 in Q2.14, other coefficients 0, pipeline emptied.
// ----------------------------------------------------------------------------
module fir_filter_mirror_boundary_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wen,
    input  logic [fmb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fmb_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample
    input  logic                              s_axis_tlast,   // end_of_profile
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fmb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [19:0] filtered
    output logic                              m_axis_tlast    // final_output
);
    import fmb_pkg::*;

    // configuration
    logic [2:0] tap_count_reg;
    coef_t      coef_reg [MAX_TAPS];

    // sample history, newest first
    sample_t    history_reg [HIST_DEPTH];
    logic [2:0] seen_reg;

    // issue slot
    logic       j_valid_reg;
    logic       j_multi_reg;
    logic [1:0] j_d_reg;
    logic [2:0] j_c_reg;

    // product stage
    logic       p_valid_reg;
    logic       p_final_reg;
    prod_t      prod_reg [MAX_TAPS];

    // output stage
    logic                 o_valid_reg;
    logic                 o_final_reg;
    logic [OUT_W-1:0]     o_data_reg;

    logic       o_ready;
    logic       p_ready;
    logic       j_issue;
    logic       j_done;
    logic       s_accept;
    logic [1:0] off;
    logic [2:0] seen_next;
    logic [1:0] start_d;
    logic       issue_final;
    prod_t      prod_next [MAX_TAPS];
    acc_t       acc_sum;
    acc_t       acc_shift;

    assign off = tap_count_reg[2:1];

    assign o_ready  = !o_valid_reg || m_axis_tready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign j_issue  = j_valid_reg && p_ready;
    assign j_done   = !j_multi_reg || (j_d_reg == 2'd0);
    assign s_axis_tready = !j_valid_reg || (j_issue && j_done);
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign seen_next = (seen_reg < 3'(HIST_DEPTH)) ? seen_reg + 3'd1 : seen_reg;
    // first pending output on end of profile: min(c - 1, off)
    assign start_d = ((seen_next - 3'd1) < {1'b0, off}) ? 2'(seen_next - 3'd1) : off;
    assign issue_final = j_multi_reg && (j_d_reg == 2'd0);

    always_comb
    begin
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            logic [2:0] k;
            coef_t      cf;
            k  = mirror_index(j_c_reg, j_d_reg, off, 3'(j));
            cf = (3'(j) < tap_count_reg) ? coef_reg[j] : '0;
            prod_next[j] = PROD_W'(cf * history_reg[k]);
        end
    end

    always_comb
    begin
        acc_sum = '0;
        for (int j = 0; j < MAX_TAPS; j++)
            acc_sum = acc_sum + ACC_W'(prod_reg[j]);
        acc_shift = acc_sum >>> FRAC_BITS;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= 3'd1;
            coef_reg[0]   <= 16'sd16384;
            for (int i = 1; i < MAX_TAPS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TAP_COUNT: tap_count_reg <= cfg_data[2:0];
                default:       coef_reg[cfg_index - REG_COEF_0] <= coef_t'(cfg_data);
            endcase
        end
    end

    // history, count and issue slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                history_reg[i] <= '0;
            seen_reg    <= '0;
            j_valid_reg <= 1'b0;
            j_multi_reg <= 1'b0;
            j_d_reg     <= '0;
            j_c_reg     <= '0;
        end
        else if (s_accept)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
                history_reg[i] <= history_reg[i-1];
            history_reg[0] <= sample_t'(s_axis_tdata);
            j_c_reg <= seen_next;
            if (s_axis_tlast)
            begin
                seen_reg    <= '0;
                j_valid_reg <= 1'b1;
                j_multi_reg <= 1'b1;
                j_d_reg     <= start_d;
            end
            else
            begin
                seen_reg    <= seen_next;
                j_valid_reg <= ((seen_next - 3'd1) >= {1'b0, off});
                j_multi_reg <= 1'b0;
                j_d_reg     <= off;
            end
        end
        else if (j_issue)
        begin
            if (j_done)
                j_valid_reg <= 1'b0;
            else
                j_d_reg <= j_d_reg - 2'd1;
        end
    end

    // product and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
                p_valid_reg <= j_valid_reg;
            if (o_ready)
                o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (j_issue)
        begin
            p_final_reg <= issue_final;
            for (int j = 0; j < MAX_TAPS; j++)
                prod_reg[j] <= prod_next[j];
        end
        if (o_ready && p_valid_reg)
        begin
            o_final_reg <= p_final_reg;
            o_data_reg  <= acc_shift[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, o_data_reg};
    assign m_axis_tlast  = o_final_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= 3'(HIST_DEPTH))
        else $error("sample count beyond history depth");

    a_single_centre: assert property (@(posedge clk) disable iff (!rst_n)
        (j_valid_reg && !j_multi_reg) |-> (j_d_reg == off))
        else $error("mid-profile output not at centre offset");

    a_d_in_profile: assert property (@(posedge clk) disable iff (!rst_n)
        j_valid_reg |-> ({1'b0, j_d_reg} < j_c_reg))
        else $error("pending output lies before the profile start");

    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tlast) |=> (j_valid_reg && j_multi_reg && seen_reg == 3'd0))
        else $error("end of profile did not start a flush");

endmodule
